// ===== rtl/drpe_pkg.sv =====
// Shared types, register indexes and constants of the delta run pattern encoder.
package drpe_pkg;

    localparam int ENABLED_DELTAS_DEF = 4;
    localparam int COLUMN_BITS_DEF    = 32;
    localparam int DELTA_REGS         = 4;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [15:0] PLAIN_CAP   = 16'hFFFF;
    localparam logic [15:0] MIN_RUN_RST = 16'd4;
    localparam logic [15:0] MAX_RUN_RST = 16'd255;

    typedef enum logic [2:0] {
        REG_MIN_RUN       = 3'd0,
        REG_MAX_RUN       = 3'd1,
        REG_ENABLED_COUNT = 3'd2,
        REG_DELTA_A       = 3'd3,
        REG_DELTA_B       = 3'd4,
        REG_DELTA_C       = 3'd5,
        REG_DELTA_D       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [31:0] column;
        logic        segment_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] start_column;
        logic [31:0] stride;
        logic [15:0] element_count;
        logic        is_pattern;
        logic        segment_done;
        logic        last_of_item;
    } out_item_t;

    typedef struct packed {
        logic [15:0] eff_min;
        logic [15:0] eff_max;
    } run_limits_t;

endpackage

// ===== rtl/drpe_cfg.sv =====
// Configuration registers and derived run limits / enabled-delta mask.
module drpe_cfg #(
    parameter int ENABLED_DELTAS = drpe_pkg::ENABLED_DELTAS_DEF,
    localparam int NUM_DELTA = (ENABLED_DELTAS < drpe_pkg::DELTA_REGS) ?
                               ENABLED_DELTAS : drpe_pkg::DELTA_REGS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    output drpe_pkg::run_limits_t         limits,
    output logic [NUM_DELTA-1:0][31:0]    delta,
    output logic [NUM_DELTA-1:0]          delta_valid
);
    import drpe_pkg::*;

    logic [15:0]                 min_run_reg;
    logic [15:0]                 max_run_reg;
    logic [2:0]                  enabled_count_reg;
    logic [NUM_DELTA-1:0][31:0]  delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg       <= MIN_RUN_RST;
            max_run_reg       <= MAX_RUN_RST;
            enabled_count_reg <= 3'd0;
            for (int i = 0; i < NUM_DELTA; i++)
            begin
                delta_reg[i] <= (i == 0) ? 32'd1 : 32'd0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_MIN_RUN)
                min_run_reg <= cfg_data[15:0];
            if (cfg_index == REG_MAX_RUN)
                max_run_reg <= cfg_data[15:0];
            if (cfg_index == REG_ENABLED_COUNT)
                enabled_count_reg <= cfg_data[2:0];
            for (int i = 0; i < NUM_DELTA; i++)
            begin
                if (cfg_index == 3'(REG_DELTA_A + i))
                    delta_reg[i] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        limits.eff_min = (min_run_reg == 16'd0) ? 16'd1 : min_run_reg;
        limits.eff_max = (max_run_reg < limits.eff_min) ? limits.eff_min : max_run_reg;
        for (int i = 0; i < NUM_DELTA; i++)
        begin
            delta_valid[i] = (4'(enabled_count_reg) > 4'(i));
        end
    end

    assign delta = delta_reg;

endmodule

// ===== rtl/drpe_core.sv =====
// Run state and single-pass descriptor generation for one column beat.
module drpe_core #(
    parameter int ENABLED_DELTAS = drpe_pkg::ENABLED_DELTAS_DEF,
    parameter int COLUMN_BITS    = drpe_pkg::COLUMN_BITS_DEF,
    localparam int NUM_DELTA = (ENABLED_DELTAS < drpe_pkg::DELTA_REGS) ?
                               ENABLED_DELTAS : drpe_pkg::DELTA_REGS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  drpe_pkg::in_item_t            item,
    input  drpe_pkg::run_limits_t         limits,
    input  logic [NUM_DELTA-1:0][31:0]    delta,
    input  logic [NUM_DELTA-1:0]          delta_valid,
    output logic [1:0]                    push_cnt,
    output drpe_pkg::out_item_t           push0,
    output drpe_pkg::out_item_t           push1
);
    import drpe_pkg::*;

    logic [COLUMN_BITS-1:0] prev_col_reg, prev_col_next;
    logic [COLUMN_BITS-1:0] run_stride_reg, run_stride_next;
    logic [COLUMN_BITS-1:0] run_start_reg, run_start_next;
    logic [15:0]            run_length_reg, run_length_next;
    logic                   run_open_reg, run_open_next;

    logic [63:0]            col_wide;
    logic [COLUMN_BITS-1:0] col;
    logic [COLUMN_BITS-1:0] d;
    logic [COLUMN_BITS-1:0] stride1;
    logic [COLUMN_BITS-1:0] start1;
    logic [15:0]            len1;
    logic [15:0]            cap;
    logic                   match;
    logic                   en_old;
    logic                   en_d;
    logic                   en1;
    logic                   emit1;
    logic                   emit2;
    logic [63:0]            old_start_w, old_stride_w, start1_w, stride1_w;
    out_item_t              res1;
    out_item_t              res2;

    always_comb
    begin
        col_wide = 64'(item.column);
        col      = col_wide[COLUMN_BITS-1:0];
        d        = col - prev_col_reg;
        match    = run_open_reg && (d == run_stride_reg);

        en_old = 1'b0;
        en_d   = 1'b0;
        for (int i = 0; i < NUM_DELTA; i++)
        begin
            if (delta_valid[i] && (64'(delta[i]) == 64'(run_stride_reg)))
                en_old = 1'b1;
            if (delta_valid[i] && (64'(delta[i]) == 64'(d)))
                en_d = 1'b1;
        end

        emit1   = !match && (run_length_reg != 16'd0);
        stride1 = match ? run_stride_reg : d;
        start1  = (match && (run_length_reg != 16'd0)) ? run_start_reg : col;
        len1    = match ? (run_length_reg + 16'd1) : 16'd1;
        en1     = match ? en_old : en_d;
        cap     = en1 ? limits.eff_max : PLAIN_CAP;
        emit2   = (len1 >= cap) || item.segment_end;

        old_start_w  = 64'(run_start_reg);
        old_stride_w = 64'(run_stride_reg);
        start1_w     = 64'(start1);
        stride1_w    = 64'(stride1);

        res1.start_column  = old_start_w[31:0];
        res1.stride        = old_stride_w[31:0];
        res1.element_count = run_length_reg;
        res1.is_pattern    = en_old && (run_length_reg >= limits.eff_min);
        res1.segment_done  = 1'b0;
        res1.last_of_item  = !emit2;

        res2.start_column  = start1_w[31:0];
        res2.stride        = stride1_w[31:0];
        res2.element_count = len1;
        res2.is_pattern    = en1 && (len1 >= limits.eff_min);
        res2.segment_done  = item.segment_end;
        res2.last_of_item  = 1'b1;

        push0    = emit1 ? res1 : res2;
        push1    = res2;
        push_cnt = accept ? (2'(emit1) + 2'(emit2)) : 2'd0;

        prev_col_next   = prev_col_reg;
        run_stride_next = run_stride_reg;
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        if (accept)
        begin
            if (item.segment_end)
            begin
                prev_col_next   = '0;
                run_stride_next = '0;
                run_start_next  = '0;
                run_length_next = 16'd0;
                run_open_next   = 1'b0;
            end
            else
            begin
                prev_col_next   = col;
                run_stride_next = stride1;
                run_start_next  = start1;
                run_length_next = emit2 ? 16'd0 : len1;
                run_open_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_col_reg   <= '0;
            run_stride_reg <= '0;
            run_start_reg  <= '0;
            run_length_reg <= 16'd0;
            run_open_reg   <= 1'b0;
        end
        else
        begin
            prev_col_reg   <= prev_col_next;
            run_stride_reg <= run_stride_next;
            run_start_reg  <= run_start_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

endmodule

// ===== rtl/drpe_out_queue.sv =====
// Descriptor output queue: up to two writes and one read per cycle.
module drpe_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  drpe_pkg::out_item_t  push0,
    input  drpe_pkg::out_item_t  push1,
    output logic                 desc_valid,
    input  logic                 desc_ready,
    output drpe_pkg::out_item_t  desc,
    output logic [2:0]           fill
);
    import drpe_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    out_item_t          mem [QUEUE_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]         count_reg, count_next;
    logic               pop;

    always_comb
    begin
        pop         = desc_valid && desc_ready;
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + 3'(push_cnt) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + PW'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign desc_valid = (count_reg != 3'd0);
    assign desc       = mem[rd_ptr_reg];
    assign fill       = count_reg;

endmodule

// ===== rtl/delta_run_pattern_encoder_top.sv =====
// Delta run pattern encoder top level: config, run core, output queue.
// A descriptor enters the output queue at the edge that takes its column beat.
// Throughput: one column beat per cycle; each beat yields zero to two descriptors, drained
// one per ready cycle through a four-entry queue that holds off input below two free slots.
// Reset (rst_n, async, active low) empties the queue, clears the run state and
// loads the register defaults.
module delta_run_pattern_encoder_top #(
    parameter int ENABLED_DELTAS = drpe_pkg::ENABLED_DELTAS_DEF,
    parameter int COLUMN_BITS    = drpe_pkg::COLUMN_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  drpe_pkg::in_item_t   item,
    output logic                 desc_valid,
    input  logic                 desc_ready,
    output drpe_pkg::out_item_t  desc
);
    import drpe_pkg::*;

    localparam int NUM_DELTA = (ENABLED_DELTAS < DELTA_REGS) ? ENABLED_DELTAS : DELTA_REGS;

    run_limits_t                 limits;
    logic [NUM_DELTA-1:0][31:0]  delta;
    logic [NUM_DELTA-1:0]        delta_valid;
    logic [1:0]                  push_cnt;
    out_item_t                   push0;
    out_item_t                   push1;
    logic [2:0]                  fill;
    logic                        accept;

    assign item_ready = (fill <= 3'(QUEUE_DEPTH - 2));
    assign accept     = item_valid && item_ready;

    drpe_cfg #(
        .ENABLED_DELTAS(ENABLED_DELTAS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .limits      (limits),
        .delta       (delta),
        .delta_valid (delta_valid)
    );

    drpe_core #(
        .ENABLED_DELTAS(ENABLED_DELTAS),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .limits      (limits),
        .delta       (delta),
        .delta_valid (delta_valid),
        .push_cnt    (push_cnt),
        .push0       (push0),
        .push1       (push1)
    );

    drpe_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (push0),
        .push1      (push1),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .fill       (fill)
    );

    // queue never overfills
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= 3'(QUEUE_DEPTH))
        else $error("output queue overflow");

    // a segment end always produces a descriptor
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.segment_end |-> push_cnt != 2'd0)
        else $error("segment end without descriptor");

    // descriptors leave only by a handshake
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(desc_valid) |-> $past(desc_valid && desc_ready))
        else $error("descriptor dropped");

    // no descriptors without an accepted beat
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> push_cnt == 2'd0)
        else $error("descriptor pushed without input beat");

endmodule

// ===== test/delta_run_pattern_encoder_top_tb.sv =====
// Self-checking testbench for delta_run_pattern_encoder_top: directed rows, random phases.
module delta_run_pattern_encoder_top_tb;
    import drpe_pkg::*;

    typedef enum logic {ROW_COLUMN, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reg_index_t  index;
        logic [31:0] value;
        bit          seg_end;
        bit          typed;
        int          n_typed;
        out_item_t   d0;
        out_item_t   d1;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    in_item_t    item = '0;
    logic        desc_valid;
    logic        desc_ready = 1'b0;
    out_item_t   desc;

    delta_run_pattern_encoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    // register shadow
    logic [15:0] min_run_r = MIN_RUN_RST;
    logic [15:0] max_run_r = MAX_RUN_RST;
    logic [2:0]  en_count_r = '0;
    logic [31:0] en_delta_r [DELTA_REGS] = '{32'd1, 32'd0, 32'd0, 32'd0};

    // run state
    logic [31:0] prev_col = '0;
    logic [31:0] run_stride = '0;
    logic [31:0] run_start = '0;
    int          run_len = 0;
    bit          run_open = 1'b0;

    out_item_t   pending_descs[$];
    out_item_t   step_descs[$];
    out_item_t   typed_descs[$];
    script_row_t script[$];

    logic [31:0] gen_col = '0;
    logic [31:0] gen_stride = '0;
    int          run_left = 0;

    int errors = 0;
    int items_sent = 0;
    int descs_seen = 0;
    int patterns_seen = 0;
    bit steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic int active_deltas();
        int n;
        n = en_count_r;
        if (n > ENABLED_DELTAS_DEF)
            n = ENABLED_DELTAS_DEF;
        if (n > DELTA_REGS)
            n = DELTA_REGS;
        return n;
    endfunction

    function automatic int floor_run();
        return (min_run_r < 16'd1) ? 1 : int'(min_run_r);
    endfunction

    function automatic int chunk_limit();
        int m;
        m = floor_run();
        return (int'(max_run_r) < m) ? m : int'(max_run_r);
    endfunction

    function automatic bit stride_enabled(logic [31:0] d);
        for (int i = 0; i < active_deltas(); i++)
            if (en_delta_r[i] == d)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic out_item_t descriptor(logic [31:0] s, logic [31:0] st, logic [15:0] n,
                                             bit pat, bit done, bit last);
        out_item_t r;
        r.start_column  = s;
        r.stride        = st;
        r.element_count = n;
        r.is_pattern    = pat;
        r.segment_done  = done;
        r.last_of_item  = last;
        return r;
    endfunction

    function automatic void close_run();
        bit pat;
        if (run_len == 0)
            return;
        pat = stride_enabled(run_stride) && run_len >= floor_run();
        step_descs.insert(step_descs.size(),
                          descriptor(run_start, run_stride, run_len[15:0], pat, 1'b0, 1'b0));
        run_len = 0;
    endfunction

    function automatic void encode_column(logic [31:0] col, bit seg_end);
        logic [31:0] d;
        int          cap;
        out_item_t   r;
        step_descs.delete();
        d = col - prev_col;
        if (run_open && d == run_stride)
        begin
            if (run_len == 0)
                run_start = col;
            run_len++;
        end
        else
        begin
            close_run();
            run_open   = 1'b1;
            run_stride = d;
            run_start  = col;
            run_len    = 1;
        end
        cap = stride_enabled(run_stride) ? chunk_limit() : int'(PLAIN_CAP);
        if (run_len >= cap)
            close_run();
        prev_col = col;
        if (seg_end)
        begin
            close_run();
            prev_col   = '0;
            run_open   = 1'b0;
            run_stride = '0;
            run_start  = '0;
            run_len    = 0;
        end
        if (step_descs.size() > 0)
        begin
            r = step_descs[step_descs.size() - 1];
            r.last_of_item = 1'b1;
            r.segment_done = seg_end;
            step_descs[step_descs.size() - 1] = r;
        end
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_RUN:       min_run_r = val[15:0];
            REG_MAX_RUN:       max_run_r = val[15:0];
            REG_ENABLED_COUNT: en_count_r = val[2:0];
            REG_DELTA_A:       en_delta_r[0] = val;
            REG_DELTA_B:       en_delta_r[1] = val;
            REG_DELTA_C:       en_delta_r[2] = val;
            REG_DELTA_D:       en_delta_r[3] = val;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_descs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_column(logic [31:0] col, bit seg_end, bit use_typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid        <= 1'b1;
        item.column       <= col;
        item.segment_end  <= seg_end;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        // beat taken at this edge
        encode_column(col, seg_end);
        items_sent++;
        if (use_typed)
            foreach (typed_descs[i])
                pending_descs.insert(pending_descs.size(), typed_descs[i]);
        else
            foreach (step_descs[i])
                pending_descs.insert(pending_descs.size(), step_descs[i]);
    endtask

    task automatic add_write(reg_index_t idx, logic [31:0] val);
        script_row_t row;
        row = '{ROW_WRITE, idx, val, 1'b0, 1'b0, 0, '0, '0};
        script.insert(script.size(), row);
    endtask

    task automatic add_col(logic [31:0] col, bit seg_end);
        script_row_t row;
        row = '{ROW_COLUMN, REG_MIN_RUN, col, seg_end, 1'b0, 0, '0, '0};
        script.insert(script.size(), row);
    endtask

    task automatic add_typed(logic [31:0] col, bit seg_end, int n, out_item_t d0, out_item_t d1);
        script_row_t row;
        row = '{ROW_COLUMN, REG_MIN_RUN, col, seg_end, 1'b1, n, d0, d1};
        script.insert(script.size(), row);
    endtask

    task automatic random_config();
        logic [15:0] v16;
        logic [31:0] v32;
        case ($urandom_range(0, 5))
            0:       v16 = 16'd0;
            1:       v16 = 16'd1;
            2:       v16 = 16'd2;
            3:       v16 = 16'hFFFF;
            default: v16 = 16'($urandom_range(2, 8));
        endcase
        write_reg(REG_MIN_RUN, {16'($urandom()), v16});
        case ($urandom_range(0, 5))
            0:       v16 = 16'd0;
            1:       v16 = 16'd2;
            2:       v16 = 16'hFFFF;
            3:       v16 = 16'd255;
            default: v16 = 16'($urandom_range(2, 24));
        endcase
        write_reg(REG_MAX_RUN, {16'($urandom()), v16});
        write_reg(REG_ENABLED_COUNT, {29'($urandom()), 3'($urandom_range(0, 7))});
        for (int i = 0; i < DELTA_REGS; i++)
        begin
            case ($urandom_range(0, 4))
                3:       v32 = $urandom();
                4:       v32 = 32'hFFFF_FFFF;
                default: v32 = 32'($urandom_range(0, 5));
            endcase
            write_reg(reg_index_t'(int'(REG_DELTA_A) + i), v32);
        end
    endtask

    task automatic random_phase(int count);
        int          r;
        int          n;
        int          lim;
        logic [31:0] col;
        bit          seg_end;
        for (int k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                n = active_deltas();
                r = $urandom_range(0, 99);
                if (n > 0 && r < 65)
                    gen_stride = en_delta_r[$urandom_range(0, n - 1)];
                else if (r < 85)
                    gen_stride = 32'($urandom_range(0, 6));
                else
                    gen_stride = $urandom();
                lim = chunk_limit();
                if (lim > 20)
                    lim = 20;
                r = $urandom_range(0, 9);
                if (r < 5)
                    run_left = $urandom_range(1, 6);
                else if (r < 8)
                    run_left = $urandom_range(1, 3 * lim);
                else
                    run_left = $urandom_range(1, 60);
            end
            if ($urandom_range(0, 99) < 3)
                col = $urandom();
            else
                col = gen_col + gen_stride;
            run_left--;
            seg_end = (run_left == 0 && $urandom_range(0, 5) == 0) || $urandom_range(0, 99) == 0;
            send_column(col, seg_end, 1'b0);
            if (seg_end)
            begin
                run_left = 0;
                gen_col  = ($urandom_range(0, 9) < 7) ? 32'd0 : $urandom();
            end
            else
                gen_col = col;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                desc_ready <= 1'b0;
                stall--;
            end
            else
            begin
                desc_ready <= 1'b1;
                if (!steady && $urandom_range(0, 4) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && desc_valid && desc_ready)
        begin
            descs_seen++;
            if (desc.is_pattern)
                patterns_seen++;
            if (pending_descs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected descriptor expected none actual %h", $time, desc);
            end
            else
            begin
                want = pending_descs.pop_front();
                check_field("start_column", want.start_column, desc.start_column);
                check_field("stride", want.stride, desc.stride);
                check_field("element_count", 32'(want.element_count), 32'(desc.element_count));
                check_field("is_pattern", 32'(want.is_pattern), 32'(desc.is_pattern));
                check_field("segment_done", 32'(want.segment_done), 32'(desc.segment_done));
                check_field("last_of_item", 32'(want.last_of_item), 32'(desc.last_of_item));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Run stopped by timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int phases;
        int random_items;
        int base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset: nothing enabled, everything plain
        add_typed(32'd0, 1'b1, 1, descriptor(32'd0, 32'd0, 16'd1, 0, 1, 1), '0);
        add_typed(32'hFFFF_FFFF, 1'b1, 1,
                  descriptor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 0, 1, 1), '0);
        add_write(REG_MIN_RUN, 32'd2);
        add_write(REG_MAX_RUN, 32'd3);
        add_write(REG_ENABLED_COUNT, 32'd2);
        add_write(REG_DELTA_A, 32'd1);
        add_write(REG_DELTA_B, 32'hFFFF_FFFF);
        add_col(32'd5, 1'b0);
        add_typed(32'd6, 1'b0, 1, descriptor(32'd5, 32'd5, 16'd1, 0, 0, 1), '0);
        add_col(32'd7, 1'b0);
        add_typed(32'd8, 1'b0, 1, descriptor(32'd6, 32'd1, 16'd3, 1, 0, 1), '0);
        add_col(32'd9, 1'b0);
        // descending columns wrap the delta
        add_typed(32'd7, 1'b0, 1, descriptor(32'd9, 32'd1, 16'd1, 0, 0, 1), '0);
        add_typed(32'd6, 1'b0, 1, descriptor(32'd7, 32'hFFFF_FFFE, 16'd1, 0, 0, 1), '0);
        add_typed(32'd5, 1'b1, 1, descriptor(32'd6, 32'hFFFF_FFFF, 16'd2, 1, 1, 1), '0);
        add_col(32'd10, 1'b0);
        add_typed(32'd11, 1'b1, 2, descriptor(32'd10, 32'd10, 16'd1, 0, 0, 0),
                  descriptor(32'd11, 32'd1, 16'd1, 0, 1, 1));
        // chunk limit lowered to the held length
        add_col(32'd1, 1'b0);
        add_col(32'd2, 1'b0);
        add_write(REG_MAX_RUN, 32'd0);
        add_typed(32'd3, 1'b0, 1, descriptor(32'd1, 32'd1, 16'd3, 1, 0, 1), '0);
        add_write(REG_MIN_RUN, 32'd0);
        add_write(REG_MAX_RUN, 32'd0);
        add_typed(32'd4, 1'b0, 1, descriptor(32'd4, 32'd1, 16'd1, 1, 0, 1), '0);
        add_typed(32'd5, 1'b1, 1, descriptor(32'd5, 32'd1, 16'd1, 1, 1, 1), '0);
        // count above four saturates
        add_write(REG_ENABLED_COUNT, 32'd7);
        add_write(REG_DELTA_C, 32'd3);
        add_write(REG_DELTA_D, 32'd0);
        add_write(REG_MIN_RUN, 32'h0000_FFFF);
        add_write(REG_MAX_RUN, 32'h0000_FFFF);
        add_col(32'd3, 1'b0);
        add_col(32'd6, 1'b0);
        add_typed(32'd6, 1'b0, 1, descriptor(32'd3, 32'd3, 16'd2, 0, 0, 1), '0);
        add_typed(32'd6, 1'b1, 1, descriptor(32'd6, 32'd0, 16'd2, 0, 1, 1), '0);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(script[i].index, script[i].value);
            end
            else
            begin
                typed_descs.delete();
                if (script[i].n_typed > 0)
                    typed_descs.insert(typed_descs.size(), script[i].d0);
                if (script[i].n_typed > 1)
                    typed_descs.insert(typed_descs.size(), script[i].d1);
                send_column(script[i].value, script[i].seg_end, script[i].typed);
            end
        end

        phases = 0;
        base = items_sent;
        random_items = 0;
        while (random_items < 2000)
        begin
            wait_idle();
            random_config();
            steady = (phases % 4 == 3);
            random_phase($urandom_range(60, 200));
            phases++;
            random_items = items_sent - base;
        end
        steady = 1'b0;

        item_valid <= 1'b0;
        while (pending_descs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d columns (%0d random over %0d register settings)",
                 items_sent, random_items, phases);
        $display("Checked %0d descriptors, %0d of them patterns", descs_seen, patterns_seen);
        if (errors == 0 && pending_descs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
